// ----- rtl/core/isett_pkg.sv -----
package isett_pkg;

  localparam int unsigned ElemWidth  = 32;
  localparam int unsigned CapWidth   = 7;
  localparam int unsigned IndexWidth = 6;
  localparam int unsigned CountWidth = 7;
  localparam logic [CapWidth-1:0] CapacityReset = 7'd64;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_ACT,
    ST_MOVE,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic append;
    logic rd_last;
    logic move;
    logic set_ok;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  add_full;
    logic  rem_empty;
    logic  empty;
    logic  hit;
    logic  last;
    logic  found;
  } status_t;

endpackage

// ----- rtl/core/isett_ram.sv -----
module isett_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/isett_ctrl.sv -----
module isett_ctrl import isett_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    in_ready       = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (st.func == FUNC_NONE || st.add_full || st.rem_empty) begin
          state_next = ST_RESP;
        end else if (st.empty) begin
          state_next = ST_ACT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.hit || st.last) begin
          state_next = ST_ACT;
        end
      end
      ST_ACT: begin
        state_next = ST_RESP;
        unique case (st.func)
          FUNC_ADD: begin
            cmd.set_ok = 1'b1;
            cmd.append = !st.found;
          end
          FUNC_REMOVE: begin
            if (st.found) begin
              cmd.rd_last = 1'b1;
              state_next  = ST_MOVE;
            end
          end
          FUNC_SEARCH: begin
            cmd.set_ok = st.found;
          end
          default: begin
          end
        endcase
      end
      ST_MOVE: begin
        cmd.move   = 1'b1;
        cmd.set_ok = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A finished result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending transfer");

  // A move always follows the read of the last entry.
  a_move_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE) |-> $past(cmd.rd_last))
    else $error("move without a preceding last-entry read");

endmodule

// ----- rtl/core/isett_dp.sv -----
module isett_dp import isett_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               st,
  input  logic                  cfg_we,
  input  logic [CapWidth-1:0]   cfg_data,
  input  logic [1:0]            func,
  input  logic [ElemWidth-1:0]  element,
  output logic                  ok,
  output logic [IndexWidth-1:0] index,
  output logic [CountWidth-1:0] count
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned FW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LW = (FW > CapWidth) ? FW : CapWidth;

  logic [CapWidth-1:0]  capacity;
  logic [FW-1:0]        fill;
  logic [FW-1:0]        fill_m1;
  logic [FW-1:0]        ptr;
  logic [AW-1:0]        cmp_ptr;
  logic                 cmp_vld;
  logic [AW-1:0]        slot;
  logic                 found;
  logic                 res_ok;
  func_t                func_r;
  logic [ElemWidth-1:0] elem_r;

  logic                 issue;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [ElemWidth-1:0] ram_wdata;
  logic [ElemWidth-1:0] ram_rdata;

  assign fill_m1 = fill - FW'(1);
  assign issue   = cmd.scan && (ptr < fill);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = ptr[AW-1:0];
    ram_wdata = elem_r;
    priority if (cmd.append) begin
      ram_we   = 1'b1;
      ram_addr = fill[AW-1:0];
    end else if (cmd.move) begin
      // The old last entry fills the freed slot.
      ram_we    = 1'b1;
      ram_addr  = slot;
      ram_wdata = ram_rdata;
    end else if (cmd.rd_last) begin
      ram_addr = fill_m1[AW-1:0];
    end else begin
      ram_addr = ptr[AW-1:0];
    end
  end

  isett_ram #(
    .WIDTH(ElemWidth),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    st.func      = func_r;
    st.add_full  = (LW'(fill) >= LW'(capacity)) || (fill == FW'(MAX_ENTRIES));
    st.rem_empty = (func_r == FUNC_REMOVE) && (fill == '0);
    st.add_full  = st.add_full && (func_r == FUNC_ADD);
    st.empty     = (fill == '0);
    st.hit       = cmp_vld && (ram_rdata == elem_r);
    st.last      = cmp_vld && (FW'(cmp_ptr) == fill_m1);
    st.found     = found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapacityReset;
      fill     <= '0;
      cmp_vld  <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (cmd.append) begin
        fill <= fill + FW'(1);
      end else if (cmd.rd_last) begin
        fill <= fill_m1;
      end
      cmp_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func_t'(func);
      elem_r <= element;
      ptr    <= '0;
      found  <= 1'b0;
      slot   <= '0;
      res_ok <= 1'b0;
    end else begin
      if (issue) begin
        ptr <= ptr + FW'(1);
      end
      cmp_ptr <= ptr[AW-1:0];
      if (cmd.scan && st.hit && !found) begin
        found <= 1'b1;
        slot  <= cmp_ptr;
      end
      if (cmd.append) begin
        slot <= fill[AW-1:0];
      end
      if (cmd.set_ok) begin
        res_ok <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      ok    <= res_ok;
      index <= res_ok ? IndexWidth'(slot) : '0;
      count <= CountWidth'(fill);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(MAX_ENTRIES))
    else $error("fill beyond table depth");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> !st.add_full && !found)
    else $error("append into a full table or of a present element");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_last |=> fill == $past(fill) - FW'(1))
    else $error("remove did not shrink the fill");

endmodule

// ----- rtl/core/integer_set_table.sv -----
// Channel  | Handshake           | Payload
// ---------+---------------------+----------------------------
// in       | in_valid, in_ready  | func, element
// out      | out_valid, out_ready| ok, index, count
// cfg      | cfg_we              | cfg_data (capacity)
//
// A request passes through latch, decide, a scan that reads the entries from the RAM in turn,
// act, a move of the last entry on a remove that hits, and post.
// A hit ends the scan early; with an empty set or an early verdict the scan is skipped.
// Reset clears the fill count and sets capacity to 64; the entry RAM is not cleared.
// A new request is taken while the previous result waits; its own result then waits in
// place until the output register is free.
module integer_set_table import isett_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic signed [ElemWidth-1:0]  element,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         ok,
  output logic [IndexWidth-1:0]        index,
  output logic [CountWidth-1:0]        count,
  input  logic                         cfg_we,
  input  logic [CapWidth-1:0]          cfg_data
);

  cmd_t    cmd;
  status_t st;

  isett_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .st       (st),
    .cmd      (cmd)
  );

  isett_dp #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .st      (st),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .func    (func),
    .element (element),
    .ok      (ok),
    .index   (index),
    .count   (count)
  );

endmodule

// ----- sim/integer_set_table_test.sv -----
module integer_set_table_test;
  import isett_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD = 1500;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam int unsigned POOL_DEPTH = 80;

  typedef struct packed {
    logic                  ok;
    logic [IndexWidth-1:0] index;
    logic [CountWidth-1:0] count;
  } set_result_t;

  class set_scoreboard;
    logic [ElemWidth-1:0] slots [SLOTS];
    int unsigned fill_n;
    int unsigned cap;
    set_result_t expected_q [$];
    int unsigned errors;

    function new();
      fill_n = 0;
      cap = 32'(CapacityReset);
      errors = 0;
    endfunction

    function void set_capacity(logic [CapWidth-1:0] value);
      cap = 32'(value);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int find_slot(logic [ElemWidth-1:0] value);
      for (int k = 0; k < fill_n; k++) begin
        if (slots[k] == value) return k;
      end
      return -1;
    endfunction

    // Applies one accepted request to the shadow set and queues its result.
    function void note_request(func_t op, logic [ElemWidth-1:0] value);
      int unsigned limit;
      int pos;
      set_result_t res;
      limit = (cap < SLOTS) ? cap : SLOTS;
      res = '0;
      case (op)
        FUNC_ADD: begin
          if (fill_n < limit) begin
            pos = find_slot(value);
            if (pos >= 0) begin
              res.index = IndexWidth'(pos);
            end else begin
              res.index = IndexWidth'(fill_n);
              slots[fill_n] = value;
              fill_n++;
            end
            res.ok = 1'b1;
          end
        end
        FUNC_REMOVE: begin
          pos = find_slot(value);
          if (fill_n > 0 && pos >= 0) begin
            res.index = IndexWidth'(pos);
            fill_n--;
            slots[pos] = slots[fill_n];
            res.ok = 1'b1;
          end
        end
        FUNC_SEARCH: begin
          pos = find_slot(value);
          if (pos >= 0) begin
            res.index = IndexWidth'(pos);
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.count = CountWidth'(fill_n);
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      if (errors < 40) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic ok, logic [IndexWidth-1:0] index, logic [CountWidth-1:0] count);
      set_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected (ok %0b index %0d count %0d)",
                         ok, index, count));
      end else begin
        want = expected_q.pop_front();
        if (ok !== want.ok)
          report($sformatf("ok got %0b expected %0b", ok, want.ok));
        if (index !== want.index)
          report($sformatf("index got %0d expected %0d", index, want.index));
        if (count !== want.count)
          report($sformatf("count got %0d expected %0d", count, want.count));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  func_t func = FUNC_NONE;
  logic signed [ElemWidth-1:0] element = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic ok;
  logic [IndexWidth-1:0] index;
  logic [CountWidth-1:0] count;
  logic cfg_we = 1'b0;
  logic [CapWidth-1:0] cfg_data = CapacityReset;

  set_scoreboard board = new();
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit hold_req = 0;
  logic [ElemWidth-1:0] pool [POOL_DEPTH];
  int unsigned pool_size = 1;

  integer_set_table #(.MAX_ENTRIES(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .element(element),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ok(ok),
    .index(index),
    .count(count),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(ok, index, count);
  end

  // The receiver switches between always ready, random stalls and a fixed
  // one-in-three pattern, and honors a request for one long hold-off.
  initial begin : receiver
    int unsigned run_left;
    int unsigned mode;
    run_left = 0;
    mode = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 0;
      end
      if (run_left == 0) begin
        mode = $urandom_range(2);
        run_left = $urandom_range(20, 200);
      end
      run_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(9) < 7);
        default: out_ready <= (run_left % 3 == 0);
      endcase
    end
  end

  // Offers one request and returns at the edge where its transfer happens.
  task automatic send_item(func_t op, logic [ElemWidth-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    func <= op;
    element <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(op, value);
    burst_left--;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_idle(int unsigned settle);
    while (board.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CapWidth-1:0] value);
    wait_idle(4);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_capacity(value);
  endtask

  // Random requests mostly on a pool that holds the current members plus
  // fresh values, alternating between filling and draining the set.
  task automatic run_phase(int unsigned phase, bit long_stall);
    int unsigned limit;
    int unsigned want;
    int unsigned roll;
    int unsigned n_add;
    int unsigned n_rem;
    func_t op;
    logic [ElemWidth-1:0] value;
    limit = (board.cap < SLOTS) ? board.cap : SLOTS;
    want = limit + limit / 8 + 3;
    pool_size = (board.fill_n > want) ? board.fill_n : want;
    for (int k = 0; k < pool_size; k++)
      pool[k] = (k < board.fill_n) ? board.slots[k] : $urandom;
    if (phase % 2 == 1) begin
      pool[pool_size - 1] = '0;
      pool[pool_size - 2] = '1;
    end
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (long_stall && i == 100) hold_req = 1;
      if ((i / 60) % 2 == 0) begin
        n_add = 60;
        n_rem = 15;
      end else begin
        n_add = 15;
        n_rem = 60;
      end
      roll = $urandom_range(99);
      if (roll < 5) begin
        op = FUNC_NONE;
      end else begin
        roll = $urandom_range(99);
        if (roll < n_add) op = FUNC_ADD;
        else if (roll < n_add + n_rem) op = FUNC_REMOVE;
        else op = FUNC_SEARCH;
      end
      if ($urandom_range(9) == 0) value = $urandom;
      else value = pool[$urandom_range(pool_size - 1)];
      send_item(op, value);
    end
    end_burst();
  endtask

  initial begin : stimulus
    logic [CapWidth-1:0] caps [8];
    caps = '{7'd127, 7'd0, 7'd1, 7'd8, 7'd64, 7'd3, 7'd40, 7'd64};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty set, zero as a member, duplicates, swap on remove, no-op code.
    send_item(FUNC_SEARCH, 32'h0000_0000);
    send_item(FUNC_REMOVE, 32'h0000_0005);
    send_item(FUNC_ADD, 32'h0000_0000);
    send_item(FUNC_ADD, 32'h0000_0000);
    send_item(FUNC_SEARCH, 32'h0000_0000);
    send_item(FUNC_ADD, 32'h8000_0000);
    send_item(FUNC_ADD, 32'h7FFF_FFFF);
    send_item(FUNC_ADD, 32'hFFFF_FFFF);
    send_item(FUNC_SEARCH, 32'hFFFF_FFFF);
    send_item(FUNC_REMOVE, 32'h0000_0000);
    send_item(FUNC_SEARCH, 32'hFFFF_FFFF);
    send_item(FUNC_NONE, 32'h0000_0007);
    send_item(FUNC_REMOVE, 32'h0000_0000);
    send_item(FUNC_ADD, 32'h5555_5555);
    send_item(FUNC_ADD, 32'hAAAA_AAAA);
    send_item(FUNC_SEARCH, 32'hAAAA_AAAA);
    send_item(FUNC_REMOVE, 32'hAAAA_AAAA);
    send_item(FUNC_SEARCH, 32'h7FFF_FFFF);
    send_item(FUNC_REMOVE, 32'h8000_0000);
    send_item(FUNC_REMOVE, 32'h7FFF_FFFF);
    send_item(FUNC_NONE, 32'hFFFF_FFFF);
    end_burst();

    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      run_phase(p, p == 4);
    end

    wait_idle(DRAIN_CYCLES);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
